### rtl/spt_pkg.sv
// shared constants, types and codes of the sparse polynomial term merge core
package spt_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int COEF_W      = 16;
  localparam int EXP_W       = 10;
  localparam int ENTRY_W     = COEF_W + EXP_W;

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(STORE_DEPTH);
  localparam logic [KCNT_W-1:0] MAX_K     = KCNT_W'(MAX_RESULTS);

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_LEAD   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_ADD_END,
    ST_FIND,
    ST_LEAD
  } state_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         exp;
    logic [IDX_W-1:0]         index;
    logic [CNT_W-1:0]         fill;
    logic                     full;
    logic                     empty;
    logic                     last;
  } res_t;

endpackage

### rtl/spt_if.sv
// request and result channel interfaces of the sparse polynomial term merge core
interface spt_req_if;
  import spt_pkg::*;
  logic                     valid;
  logic                     ready;
  cmd_e                     command;
  logic signed [COEF_W-1:0] term_coef;
  logic [EXP_W-1:0]         term_exp;
  logic [IDX_W-1:0]         first_a;
  logic [IDX_W-1:0]         last_a;
  logic [IDX_W-1:0]         first_b;
  logic [IDX_W-1:0]         last_b;

  modport source (
    output valid, command, term_coef, term_exp, first_a, last_a, first_b, last_b,
    input  ready
  );
  modport sink (
    input  valid, command, term_coef, term_exp, first_a, last_a, first_b, last_b,
    output ready
  );
endinterface

interface spt_res_if;
  import spt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] out_coef;
  logic [EXP_W-1:0]         out_exp;
  logic [IDX_W-1:0]         term_index;
  logic [CNT_W-1:0]         fill_count;
  logic                     full_error;
  logic                     empty_result;
  logic                     last_result;

  modport source (
    output valid, out_coef, out_exp, term_index, fill_count, full_error, empty_result,
           last_result,
    input  ready
  );
  modport sink (
    input  valid, out_coef, out_exp, term_index, fill_count, full_error, empty_result,
           last_result,
    output ready
  );
endinterface

### rtl/spt_ram.sv
// generic single write port, single read port ram with registered read data
module spt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sparse_poly_term_merge_core.sv
// sparse polynomial term store with merge-add, lookup and leading exponent
//
// req_i takes one command per request: append a term, add two stored runs,
// look up the coefficient of an exponent in a range, or find the largest
// exponent in a range. res_o returns results; every command ends with one
// result that has last_result set. add returns one result per merged term.
// Terms live in two copies of a 64 x 26 ram (one per read port), written
// together at the fill position; the ram registers its read data.
// Append: the result goes to the result register when the request is taken.
// Add: merge steps compare one stored term of each run, then an end step hands
// over the last result; a zero sum costs a step and gives no result.
// Lookup and lead scan one entry per step; a lookup hit hands over its result
// on the cycle of the matching entry.
// A new request is taken in the idle state once the previous command has handed
// its final result to the output register, and only when that register can take one.
// Reset empties the store (fill count zero); ram contents are not cleared.
// A stalled receiver holds the output register; add and lookup wait with it,
// lead finishes its scan and then waits to hand over its result.
module sparse_poly_term_merge_core (
  input  logic clk_i,
  input  logic rst_ni,
  spt_req_if.sink   req_i,
  spt_res_if.source res_o
);
  import spt_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   ia_q, ia_d, ib_q, ib_d;
  logic [CNT_W-1:0]   ea_q, ea_d, eb_q, eb_d;
  logic [EXP_W-1:0]   te_q, te_d;
  logic [EXP_W-1:0]   best_q, best_d;
  logic [KCNT_W-1:0]  k_q, k_d;
  res_t               pend_q, pend_d;
  logic               pend_vld_q, pend_vld_d;
  res_t               out_q, out_d;
  logic               out_vld_q, out_vld_d;

  logic               can_push, push;
  res_t               push_res;
  logic               we;
  logic [COEF_W-1:0]  wcoef;
  logic [EXP_W-1:0]   wexp;
  logic [ENTRY_W-1:0] rd_a, rd_b;
  logic signed [COEF_W-1:0] ca, cb;
  logic [EXP_W-1:0]   xa, xb;
  logic               a_ok, b_ok;
  logic signed [COEF_W:0]   sum_wide;
  logic signed [COEF_W-1:0] sum_sat;
  logic signed [COEF_W-1:0] sel_coef;
  logic [EXP_W-1:0]   sel_exp;
  logic               sel_adv_a, sel_adv_b, sel_keep;

  function automatic logic [CNT_W-1:0] range_end(input logic [IDX_W-1:0] last,
                                                 input logic [CNT_W-1:0] limit);
    logic [CNT_W-1:0] e;
    e = {1'b0, last} + 1'b1;
    return (e < limit) ? e : limit;
  endfunction

  // two copies, so both runs are read in the same cycle
  spt_ram #(.Width(ENTRY_W), .Depth(STORE_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (used_q[IDX_W-1:0]),
    .wdata_i ({wcoef, wexp}),
    .raddr_i (ia_d[IDX_W-1:0]),
    .rdata_o (rd_a)
  );

  spt_ram #(.Width(ENTRY_W), .Depth(STORE_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (used_q[IDX_W-1:0]),
    .wdata_i ({wcoef, wexp}),
    .raddr_i (ib_d[IDX_W-1:0]),
    .rdata_o (rd_b)
  );

  assign ca   = rd_a[ENTRY_W-1 -: COEF_W];
  assign xa   = rd_a[EXP_W-1:0];
  assign cb   = rd_b[ENTRY_W-1 -: COEF_W];
  assign xb   = rd_b[EXP_W-1:0];
  assign a_ok = ia_q < ea_q;
  assign b_ok = ib_q < eb_q;

  assign sum_wide = {ca[COEF_W-1], ca} + {cb[COEF_W-1], cb};
  assign sum_sat  = (sum_wide[COEF_W] != sum_wide[COEF_W-1]) ?
                    (sum_wide[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                      : {1'b0, {(COEF_W-1){1'b1}}}) :
                    sum_wide[COEF_W-1:0];

  // merge selection
  always_comb begin
    sel_coef  = cb;
    sel_exp   = xb;
    sel_adv_a = 1'b0;
    sel_adv_b = 1'b1;
    sel_keep  = 1'b1;
    if (a_ok && b_ok) begin
      if (xa > xb) begin
        sel_coef  = ca;
        sel_exp   = xa;
        sel_adv_a = 1'b1;
        sel_adv_b = 1'b0;
      end else if (xa == xb) begin
        sel_coef  = sum_sat;
        sel_exp   = xa;
        sel_adv_a = 1'b1;
        sel_keep  = (sum_sat != '0);
      end
    end else if (a_ok) begin
      sel_coef  = ca;
      sel_exp   = xa;
      sel_adv_a = 1'b1;
      sel_adv_b = 1'b0;
    end
  end

  assign can_push = !out_vld_q || res_o.ready;

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    ia_d       = ia_q;
    ib_d       = ib_q;
    ea_d       = ea_q;
    eb_d       = eb_q;
    te_d       = te_q;
    best_d     = best_q;
    k_d        = k_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    push       = 1'b0;
    push_res   = '0;
    we         = 1'b0;
    wcoef      = '0;
    wexp       = '0;
    req_i.ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = can_push;
        if (req_i.valid && can_push) begin
          te_d       = req_i.term_exp;
          ia_d       = {1'b0, req_i.first_a};
          ib_d       = {1'b0, req_i.first_b};
          ea_d       = range_end(req_i.last_a, used_q);
          eb_d       = range_end(req_i.last_b, used_q);
          best_d     = '0;
          k_d        = '0;
          pend_vld_d = 1'b0;
          case (req_i.command)
            CMD_APPEND: begin
              push          = 1'b1;
              push_res.last = 1'b1;
              if (used_q >= DEPTH_CNT) begin
                push_res.full = 1'b1;
                push_res.fill = used_q;
              end else begin
                we             = 1'b1;
                wcoef          = req_i.term_coef;
                wexp           = req_i.term_exp;
                used_d         = used_q + 1'b1;
                push_res.coef  = req_i.term_coef;
                push_res.exp   = req_i.term_exp;
                push_res.index = used_q[IDX_W-1:0];
                push_res.fill  = used_q + 1'b1;
              end
            end
            CMD_ADD:  state_d = ST_ADD;
            CMD_FIND: state_d = ST_FIND;
            CMD_LEAD: state_d = ST_LEAD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end

      ST_ADD: begin
        if (can_push) begin
          if (!a_ok && !b_ok) begin
            state_d = ST_ADD_END;
          end else begin
            if (sel_adv_a) ia_d = ia_q + 1'b1;
            if (sel_adv_b) ib_d = ib_q + 1'b1;
            if (sel_keep) begin
              // previous term is known not to be last now
              if (pend_vld_q) begin
                push     = 1'b1;
                push_res = pend_q;
              end
              pend_vld_d = 1'b1;
              k_d        = k_q + 1'b1;
              pend_d     = '0;
              if (used_q >= DEPTH_CNT) begin
                pend_d.full = 1'b1;
                pend_d.fill = used_q;
                state_d     = ST_ADD_END;
              end else begin
                we           = 1'b1;
                wcoef        = sel_coef;
                wexp         = sel_exp;
                used_d       = used_q + 1'b1;
                pend_d.coef  = sel_coef;
                pend_d.exp   = sel_exp;
                pend_d.index = used_q[IDX_W-1:0];
                pend_d.fill  = used_q + 1'b1;
                if (k_q + 1'b1 >= MAX_K) state_d = ST_ADD_END;
              end
            end
          end
        end
      end

      ST_ADD_END: begin
        if (can_push) begin
          push = 1'b1;
          if (pend_vld_q) begin
            push_res = pend_q;
          end else begin
            push_res.empty = 1'b1;
            push_res.fill  = used_q;
          end
          push_res.last = 1'b1;
          pend_vld_d    = 1'b0;
          state_d       = ST_IDLE;
        end
      end

      ST_FIND: begin
        if (can_push) begin
          if (!a_ok) begin
            push          = 1'b1;
            push_res.exp  = te_q;
            push_res.fill = used_q;
            push_res.last = 1'b1;
            state_d       = ST_IDLE;
          end else if (xa == te_q) begin
            push           = 1'b1;
            push_res.coef  = ca;
            push_res.exp   = te_q;
            push_res.index = ia_q[IDX_W-1:0];
            push_res.fill  = used_q;
            push_res.last  = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            ia_d = ia_q + 1'b1;
          end
        end
      end

      ST_LEAD: begin
        if (!a_ok) begin
          if (can_push) begin
            push          = 1'b1;
            push_res.exp  = best_q;
            push_res.fill = used_q;
            push_res.last = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          if (xa > best_q) best_d = xa;
          ia_d = ia_q + 1'b1;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && !res_o.ready;
    out_d     = out_q;
    if (push) begin
      out_vld_d = 1'b1;
      out_d     = push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      ia_q       <= '0;
      ib_q       <= '0;
      ea_q       <= '0;
      eb_q       <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      ia_q       <= ia_d;
      ib_q       <= ib_d;
      ea_q       <= ea_d;
      eb_q       <= eb_d;
      k_q        <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    te_q   <= te_d;
    best_q <= best_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.out_coef     = out_q.coef;
  assign res_o.out_exp      = out_q.exp;
  assign res_o.term_index   = out_q.index;
  assign res_o.fill_count   = out_q.fill;
  assign res_o.full_error   = out_q.full;
  assign res_o.empty_result = out_q.empty;
  assign res_o.last_result  = out_q.last;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= DEPTH_CNT)
    else $error("fill count beyond store depth");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (used_q < DEPTH_CNT))
    else $error("store write while full");

  a_pend_in_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == ST_ADD || state_q == ST_ADD_END))
    else $error("held merge term outside add");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.command == CMD_APPEND && used_q < DEPTH_CNT)
    |=> (used_q == $past(used_q) + 1'b1))
    else $error("append did not grow the store");

endmodule

### bench/tb_top.sv
// testbench of the sparse polynomial term merge core: directed and random requests
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spt_pkg::*;

  localparam int DIRECTED_N   = 25;
  localparam int RANDOM_CMDS  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 5_000_000;

  typedef struct {
    cmd_e                     command;
    logic signed [COEF_W-1:0] term_coef;
    logic [EXP_W-1:0]         term_exp;
    logic [IDX_W-1:0]         first_a;
    logic [IDX_W-1:0]         last_a;
    logic [IDX_W-1:0]         first_b;
    logic [IDX_W-1:0]         last_b;
  } term_req_t;

  typedef struct {
    term_req_t req;
    bit        typed;
    res_t      want;
  } drill_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spt_req_if req_if ();
  spt_res_if res_if ();

  sparse_poly_term_merge_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  logic signed [COEF_W-1:0] coef_mem [STORE_DEPTH];
  logic [EXP_W-1:0]         exp_mem  [STORE_DEPTH];
  int                       term_fill;
  res_t                     step_results [$];
  res_t                     awaited_results [$];
  drill_row_t               directed_cmds [DIRECTED_N];
  int                       mismatch_count = 0;
  int                       cycle_count = 0;
  bit                       steady = 1'b0;

  function automatic res_t term_result(logic signed [COEF_W-1:0] c, logic [EXP_W-1:0] e,
                                       logic [IDX_W-1:0] idx, logic full, logic empty);
    res_t t;
    t = '{coef: c, exp: e, index: idx, fill: CNT_W'(term_fill), full: full, empty: empty,
          last: 1'b0};
    return t;
  endfunction

  function automatic void store_term(logic signed [COEF_W-1:0] c, logic [EXP_W-1:0] e);
    coef_mem[term_fill] = c;
    exp_mem[term_fill]  = e;
    term_fill++;
    step_results.push_back(term_result(c, e, IDX_W'(term_fill - 1), 1'b0, 1'b0));
  endfunction

  function automatic int range_end(int last, int limit);
    return (last + 1 < limit) ? last + 1 : limit;
  endfunction

  function automatic void compute_term_results(term_req_t r);
    int                       limit, ia, ib, ea, eb, sum, i;
    logic signed [COEF_W-1:0] c;
    logic [EXP_W-1:0]         e;
    logic [EXP_W-1:0]         lead_exp;
    bit                       skip, stop, found;
    step_results.delete();
    limit = term_fill;
    ia = int'(r.first_a);
    ib = int'(r.first_b);
    ea = range_end(int'(r.last_a), limit);
    eb = range_end(int'(r.last_b), limit);
    case (r.command)
      CMD_APPEND: begin
        if (term_fill >= STORE_DEPTH) begin
          step_results.push_back(term_result('0, '0, '0, 1'b1, 1'b0));
        end else begin
          store_term(r.term_coef, r.term_exp);
        end
      end
      CMD_ADD: begin
        stop = 1'b0;
        while (!stop && (ia < ea || ib < eb)) begin
          skip = 1'b0;
          if (ia < ea && ib < eb) begin
            if (exp_mem[ia] > exp_mem[ib]) begin
              c = coef_mem[ia];
              e = exp_mem[ia];
              ia++;
            end else if (exp_mem[ia] < exp_mem[ib]) begin
              c = coef_mem[ib];
              e = exp_mem[ib];
              ib++;
            end else begin
              sum = int'(coef_mem[ia]) + int'(coef_mem[ib]);
              if (sum > 32767) sum = 32767;
              if (sum < -32768) sum = -32768;
              c = COEF_W'(sum);
              e = exp_mem[ia];
              ia++;
              ib++;
              skip = (sum == 0);
            end
          end else if (ia < ea) begin
            c = coef_mem[ia];
            e = exp_mem[ia];
            ia++;
          end else begin
            c = coef_mem[ib];
            e = exp_mem[ib];
            ib++;
          end
          if (!skip) begin
            if (term_fill >= STORE_DEPTH) begin
              step_results.push_back(term_result('0, '0, '0, 1'b1, 1'b0));
              stop = 1'b1;
            end else begin
              store_term(c, e);
              if (step_results.size() >= MAX_RESULTS) stop = 1'b1;
            end
          end
        end
        if (step_results.size() == 0) begin
          step_results.push_back(term_result('0, '0, '0, 1'b0, 1'b1));
        end
      end
      CMD_FIND: begin
        found = 1'b0;
        for (i = ia; i < ea; i++) begin
          if (!found && exp_mem[i] == r.term_exp) begin
            step_results.push_back(term_result(coef_mem[i], r.term_exp, IDX_W'(i), 1'b0, 1'b0));
            found = 1'b1;
          end
        end
        if (!found) step_results.push_back(term_result('0, r.term_exp, '0, 1'b0, 1'b0));
      end
      default: begin
        lead_exp = '0;
        for (i = ia; i < ea; i++) begin
          if (exp_mem[i] > lead_exp) lead_exp = exp_mem[i];
        end
        step_results.push_back(term_result('0, lead_exp, '0, 1'b0, 1'b0));
      end
    endcase
    step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  function automatic void pick_range(output logic [IDX_W-1:0] lo, output logic [IDX_W-1:0] hi);
    lo = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
    if ($urandom_range(0, 4) == 0) begin
      hi = IDX_W'($urandom());
    end else begin
      hi = IDX_W'($urandom_range(int'(lo), STORE_DEPTH - 1));
    end
  endfunction

  task automatic send_request(term_req_t r, bit typed, res_t typed_res);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 15));
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= r.command;
    req_if.term_coef <= r.term_coef;
    req_if.term_exp  <= r.term_exp;
    req_if.first_a   <= r.first_a;
    req_if.last_a    <= r.last_a;
    req_if.first_b   <= r.first_b;
    req_if.last_b    <= r.last_b;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    compute_term_results(r);
    if (typed) begin
      awaited_results.push_back(typed_res);
    end else begin
      foreach (step_results[k]) awaited_results.push_back(step_results[k]);
    end
  endtask

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got = '{coef: res_if.out_coef, exp: res_if.out_exp, index: res_if.term_index,
              fill: res_if.fill_count, full: res_if.full_error, empty: res_if.empty_result,
              last: res_if.last_result};
      if (awaited_results.size() == 0) begin
        $display("%0t: expected no result got %p", $time, got);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("out_coef", 16'(want.coef), 16'(got.coef));
        compare_field("out_exp", 16'(want.exp), 16'(got.exp));
        compare_field("term_index", 16'(want.index), 16'(got.index));
        compare_field("fill_count", 16'(want.fill), 16'(got.fill));
        compare_field("full_error", 16'(want.full), 16'(got.full));
        compare_field("empty_result", 16'(want.empty), 16'(got.empty));
        compare_field("last_result", 16'(want.last), 16'(got.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : int'($urandom_range(0, 15));
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
    end
  end

  initial begin
    term_req_t r;
    int        pick;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CMD_APPEND;
    req_if.term_coef <= '0;
    req_if.term_exp  <= '0;
    req_if.first_a   <= '0;
    req_if.last_a    <= '0;
    req_if.first_b   <= '0;
    req_if.last_b    <= '0;
    term_fill = 0;

    directed_cmds = '{
      // empty store
      '{'{CMD_LEAD, 16'sd0, 10'd0, 6'd0, 6'd63, 6'd0, 6'd0}, 1'b1,
        '{16'sd0, 10'd0, 6'd0, 7'd0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_FIND, 16'sd0, 10'd5, 6'd0, 6'd63, 6'd0, 6'd0}, 1'b1,
        '{16'sd0, 10'd5, 6'd0, 7'd0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd0, 6'd63, 6'd0, 6'd63}, 1'b1,
        '{16'sd0, 10'd0, 6'd0, 7'd0, 1'b0, 1'b1, 1'b1}},
      // two descending runs at 0..2 and 3..5
      '{'{CMD_APPEND, 16'sh7fff, 10'd1023, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1,
        '{16'sh7fff, 10'd1023, 6'd0, 7'd1, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_APPEND, 16'sh8000, 10'd512, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1,
        '{16'sh8000, 10'd512, 6'd1, 7'd2, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_APPEND, 16'sd100, 10'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1,
        '{16'sd100, 10'd0, 6'd2, 7'd3, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_APPEND, 16'sh7fff, 10'd1023, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1,
        '{16'sh7fff, 10'd1023, 6'd3, 7'd4, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_APPEND, 16'sh8000, 10'd600, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1,
        '{16'sh8000, 10'd600, 6'd4, 7'd5, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_APPEND, -16'sd100, 10'd0, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1,
        '{-16'sd100, 10'd0, 6'd5, 7'd6, 1'b0, 1'b0, 1'b1}},
      // merges: positive and negative saturation, cancelling terms, empty ranges; then lookups and leads
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd0, 6'd2, 6'd3, 6'd5}, 1'b0, '0},
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd1, 6'd1, 6'd1, 6'd1}, 1'b0, '0},
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd2, 6'd2, 6'd5, 6'd5}, 1'b1,
        '{16'sd0, 10'd0, 6'd0, 7'd10, 1'b0, 1'b1, 1'b1}},
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd7, 6'd3, 6'd40, 6'd50}, 1'b1,
        '{16'sd0, 10'd0, 6'd0, 7'd10, 1'b0, 1'b1, 1'b1}},
      '{'{CMD_FIND, 16'sd0, 10'd600, 6'd0, 6'd63, 6'd0, 6'd0}, 1'b0, '0},
      '{'{CMD_FIND, 16'sd0, 10'd777, 6'd0, 6'd63, 6'd0, 6'd0}, 1'b1,
        '{16'sd0, 10'd777, 6'd0, 7'd10, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_LEAD, 16'sd0, 10'd0, 6'd1, 6'd2, 6'd0, 6'd0}, 1'b0, '0},
      '{'{CMD_LEAD, 16'sd0, 10'd0, 6'd60, 6'd63, 6'd0, 6'd0}, 1'b1,
        '{16'sd0, 10'd0, 6'd0, 7'd10, 1'b0, 1'b0, 1'b1}},
      // doubling the whole store until it overflows
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd0, 6'd63, 6'd0, 6'd63}, 1'b0, '0},
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd0, 6'd63, 6'd0, 6'd63}, 1'b0, '0},
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd0, 6'd63, 6'd0, 6'd63}, 1'b0, '0},
      '{'{CMD_APPEND, 16'sd1234, 10'd77, 6'd0, 6'd0, 6'd0, 6'd0}, 1'b1,
        '{16'sd0, 10'd0, 6'd0, 7'd64, 1'b1, 1'b0, 1'b1}},
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd0, 6'd0, 6'd63, 6'd0}, 1'b1,
        '{16'sd0, 10'd0, 6'd0, 7'd64, 1'b1, 1'b0, 1'b1}},
      '{'{CMD_ADD, 16'sd0, 10'd0, 6'd2, 6'd2, 6'd5, 6'd5}, 1'b1,
        '{16'sd0, 10'd0, 6'd0, 7'd64, 1'b0, 1'b1, 1'b1}},
      '{'{CMD_FIND, 16'sd0, 10'd1023, 6'd0, 6'd63, 6'd0, 6'd0}, 1'b0, '0},
      '{'{CMD_LEAD, 16'sd0, 10'd0, 6'd0, 6'd63, 6'd0, 6'd0}, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_cmds[n]) begin
      send_request(directed_cmds[n].req, directed_cmds[n].typed, directed_cmds[n].want);
    end

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_CMDS / 2) begin
        req_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 15) r.command = CMD_APPEND;
      else if (pick < 50) r.command = CMD_ADD;
      else if (pick < 80) r.command = CMD_FIND;
      else r.command = CMD_LEAD;
      r.term_coef = COEF_W'($urandom());
      r.term_exp  = EXP_W'($urandom());
      pick_range(r.first_a, r.last_a);
      pick_range(r.first_b, r.last_b);
      // lookups mostly ask for an exponent that is really stored
      if (r.command == CMD_FIND && term_fill > 0 && $urandom_range(0, 3) != 0) begin
        r.term_exp = exp_mem[$urandom_range(0, term_fill - 1)];
      end
      send_request(r, 1'b0, '0);
    end

    req_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
